@@ rtl/cgbp_pkg.sv @@
// ----------------------------------------------------------------------------
// cgbp_pkg
// Shared types and constants of the coefficient group bit-plane packer:
// field widths, register indexes and the controller/datapath handshake.
// ----------------------------------------------------------------------------
package cgbp_pkg;

  localparam int COEF_W    = 16;
  localparam int IN_LANES  = 4;
  localparam int COUNT_W   = 4;
  localparam int VALID_W   = 3;
  localparam int NIBBLE_W  = 4;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_TRUNCATION_LEVEL = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNS_SEPARATE   = 4'd1;

  typedef logic [COEF_W-1:0]   coef_t;
  typedef logic [COUNT_W-1:0]  plane_t;
  typedef logic [NIBBLE_W-1:0] nibble_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic emit_sign;
    logic emit_plane;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic sign_needed;
    logic last_plane;
  } status_t;

endpackage

@@ rtl/coefficient_group_bitplane_packer.sv @@
// ----------------------------------------------------------------------------
// coefficient_group_bitplane_packer
// Packs one group of sign-magnitude coefficients into 4-bit words: an
// optional sign word, then one word per magnitude plane down to the
// truncation level.
//
//   channel   ports                                         direction
//   group     start, busy, coef_lane0..3, plane_count,      in
//             valid_lanes
//   result    result_valid, nibble, is_sign_nibble,         out
//             plane_index, last
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data      in
//
// A group is taken when start is high and busy is low. A group that codes
// to something keeps busy high while the plane sequencer emits one word per
// cycle: the sign word unless signs are sent separately, then one word per
// plane; an empty group leaves busy low. Each word is on the result ports
// for one cycle with result_valid high; the receiver cannot stall. rst is
// synchronous and clears the sequencer and the configuration registers.
// ----------------------------------------------------------------------------
module coefficient_group_bitplane_packer #(
  parameter int LANES          = 4,
  parameter int MAGNITUDE_BITS = 15
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [15:0]                    coef_lane0,
  input  logic [15:0]                    coef_lane1,
  input  logic [15:0]                    coef_lane2,
  input  logic [15:0]                    coef_lane3,
  input  logic [3:0]                     plane_count,
  input  logic [2:0]                     valid_lanes,
  output logic                           result_valid,
  output logic [3:0]                     nibble,
  output logic                           is_sign_nibble,
  output logic [3:0]                     plane_index,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cgbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cgbp_pkg::CFG_DAT_W-1:0] cfg_data
);

  cgbp_pkg::coef_t   coef_in [cgbp_pkg::IN_LANES];
  cgbp_pkg::cmd_t    cmd;
  cgbp_pkg::status_t status;

  assign coef_in[0] = coef_lane0;
  assign coef_in[1] = coef_lane1;
  assign coef_in[2] = coef_lane2;
  assign coef_in[3] = coef_lane3;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  cgbp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  cgbp_datapath #(
    .LANES          (LANES),
    .MAGNITUDE_BITS (MAGNITUDE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .coef_in        (coef_in),
    .plane_count    (plane_count),
    .valid_lanes    (valid_lanes),
    .cmd            (cmd),
    .status         (status),
    .result_valid   (result_valid),
    .nibble         (nibble),
    .is_sign_nibble (is_sign_nibble),
    .plane_index    (plane_index),
    .last           (last)
  );

endmodule

@@ rtl/cgbp_ctrl.sv @@
// ----------------------------------------------------------------------------
// cgbp_ctrl
// Sequencer of the packer: accepts a group, then steps through the sign
// word and the magnitude planes, one word per cycle.
// ----------------------------------------------------------------------------
module cgbp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cgbp_pkg::status_t status,
  output cgbp_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_PLANES
  } state_t;

  state_t state;

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == ST_IDLE) && start;
    cmd.emit_sign  = (state == ST_SIGN);
    cmd.emit_plane = (state == ST_PLANES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          // an empty group produces nothing; stay put
          if (start && !status.empty) begin
            state <= status.sign_needed ? ST_SIGN : ST_PLANES;
          end
        end
        ST_SIGN: begin
          state <= ST_PLANES;
        end
        ST_PLANES: begin
          if (status.last_plane) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/cgbp_datapath.sv @@
// ----------------------------------------------------------------------------
// cgbp_datapath
// Group registers, plane counter, bit gather across lanes, configuration
// registers and the registered result word.
// ----------------------------------------------------------------------------
module cgbp_datapath #(
  parameter int LANES          = 4,
  parameter int MAGNITUDE_BITS = 15
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [cgbp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cgbp_pkg::CFG_DAT_W-1:0]       cfg_data,
  input  cgbp_pkg::coef_t                      coef_in [cgbp_pkg::IN_LANES],
  input  cgbp_pkg::plane_t                     plane_count,
  input  logic [cgbp_pkg::VALID_W-1:0]         valid_lanes,
  input  cgbp_pkg::cmd_t                       cmd,
  output cgbp_pkg::status_t                    status,
  output logic                                 result_valid,
  output cgbp_pkg::nibble_t                    nibble,
  output logic                                 is_sign_nibble,
  output cgbp_pkg::plane_t                     plane_index,
  output logic                                 last
);

  // sign bit position may lie beyond the coefficient word; it then reads zero
  localparam bit SIGN_IN_RANGE = (MAGNITUDE_BITS < cgbp_pkg::COEF_W);
  localparam int SIGN_POS      = SIGN_IN_RANGE ? MAGNITUDE_BITS : 0;
  localparam bit COUNT_CAPPED  = (MAGNITUDE_BITS < (1 << cgbp_pkg::COUNT_W) - 1);
  localparam cgbp_pkg::plane_t COUNT_MAX =
    COUNT_CAPPED ? cgbp_pkg::COUNT_W'(MAGNITUDE_BITS) : '1;

  cgbp_pkg::coef_t  coef_q [cgbp_pkg::IN_LANES];
  cgbp_pkg::plane_t plane_q;
  cgbp_pkg::plane_t trunc_q;
  logic             signs_sep_q;

  cgbp_pkg::plane_t  count_sat;
  logic [LANES-1:0]  sign_bits;
  logic [LANES-1:0]  plane_bits;

  assign count_sat = (plane_count > COUNT_MAX) ? COUNT_MAX : plane_count;

  assign status.empty       = (count_sat <= trunc_q);
  assign status.sign_needed = !signs_sep_q;
  assign status.last_plane  = (plane_q == trunc_q);

  // lane i lands in bit LANES-1-i; lanes without an input port read zero
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (i < cgbp_pkg::IN_LANES) begin
        sign_bits[LANES-1-i]  = SIGN_IN_RANGE ? coef_q[i][SIGN_POS] : 1'b0;
        plane_bits[LANES-1-i] = coef_q[i][plane_q];
      end else begin
        sign_bits[LANES-1-i]  = 1'b0;
        plane_bits[LANES-1-i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trunc_q     <= '0;
      signs_sep_q <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == cgbp_pkg::REG_TRUNCATION_LEVEL) begin
        trunc_q <= cfg_data[cgbp_pkg::COUNT_W-1:0];
      end else if (cfg_index == cgbp_pkg::REG_SIGNS_SEPARATE) begin
        signs_sep_q <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_sign || cmd.emit_plane;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // drop lanes at or above the valid count
      for (int i = 0; i < cgbp_pkg::IN_LANES; i++) begin
        coef_q[i] <= (i < 32'(valid_lanes)) ? coef_in[i] : '0;
      end
      plane_q <= count_sat - 1'b1;
    end else if (cmd.emit_plane) begin
      plane_q <= plane_q - 1'b1;
    end

    if (cmd.emit_sign) begin
      nibble         <= cgbp_pkg::NIBBLE_W'(sign_bits);
      is_sign_nibble <= 1'b1;
      plane_index    <= '0;
      last           <= 1'b0;
    end else if (cmd.emit_plane) begin
      nibble         <= cgbp_pkg::NIBBLE_W'(plane_bits);
      is_sign_nibble <= 1'b0;
      plane_index    <= plane_q;
      last           <= status.last_plane;
    end
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the coefficient group bit-plane packer. Groups are sent
// through the start/busy port and the two registers through the write
// channel. A model of the packer in this file predicts the words of every
// accepted group. Each word on the result port is checked against the
// oldest prediction. Directed groups cover the field extremes and the corner
// cases; random traffic follows under changing settings and sender gaps.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DRAIN_CYCLES = 24;  // longest group plus margin

  typedef struct {
    cgbp_pkg::nibble_t bits;
    logic              sign;
    cgbp_pkg::plane_t  plane;
    logic              last;
  } word_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  cgbp_pkg::coef_t                coef_lane0 = '0;
  cgbp_pkg::coef_t                coef_lane1 = '0;
  cgbp_pkg::coef_t                coef_lane2 = '0;
  cgbp_pkg::coef_t                coef_lane3 = '0;
  cgbp_pkg::plane_t               plane_count = '0;
  logic [cgbp_pkg::VALID_W-1:0]   valid_lanes = '0;
  logic                           result_valid;
  cgbp_pkg::nibble_t              nibble;
  logic                           is_sign_nibble;
  cgbp_pkg::plane_t               plane_index;
  logic                           last;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [cgbp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cgbp_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  // shadow of the packer registers, updated on each accepted write
  cgbp_pkg::plane_t trunc_level = '0;
  logic             signs_apart = 1'b0;

  word_t  expected_words[$];
  int     error_count = 0;

  coefficient_group_bitplane_packer u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .coef_lane0     (coef_lane0),
    .coef_lane1     (coef_lane1),
    .coef_lane2     (coef_lane2),
    .coef_lane3     (coef_lane3),
    .plane_count    (plane_count),
    .valid_lanes    (valid_lanes),
    .result_valid   (result_valid),
    .nibble         (nibble),
    .is_sign_nibble (is_sign_nibble),
    .plane_index    (plane_index),
    .last           (last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Gather bit pos of every lane below valid into one word, lane 0 in the MSB.
  function automatic cgbp_pkg::nibble_t plane_bits(
    cgbp_pkg::coef_t lanes[cgbp_pkg::IN_LANES], int valid, int pos);
    cgbp_pkg::nibble_t bits;
    bits = '0;
    for (int i = 0; i < cgbp_pkg::IN_LANES; i++) begin
      if (i < valid) begin
        bits[cgbp_pkg::IN_LANES-1-i] = lanes[i][pos];
      end
    end
    return bits;
  endfunction

  // Predict the words of one group and queue them.
  function automatic void pack_group(cgbp_pkg::coef_t lanes[cgbp_pkg::IN_LANES],
                                     cgbp_pkg::plane_t count_in,
                                     logic [cgbp_pkg::VALID_W-1:0] valid_in);
    int    count;
    int    valid;
    word_t w;
    count = (count_in > 15) ? 15 : count_in;
    valid = (valid_in > cgbp_pkg::IN_LANES) ? cgbp_pkg::IN_LANES : valid_in;
    if (count <= trunc_level) begin
      return;
    end
    if (!signs_apart) begin
      w.bits  = plane_bits(lanes, valid, cgbp_pkg::COEF_W-1);
      w.sign  = 1'b1;
      w.plane = '0;
      w.last  = 1'b0;
      expected_words.push_back(w);
    end
    for (int p = count; p > trunc_level; p--) begin
      w.bits  = plane_bits(lanes, valid, p-1);
      w.sign  = 1'b0;
      w.plane = cgbp_pkg::plane_t'(p-1);
      w.last  = (p-1 == trunc_level);
      expected_words.push_back(w);
    end
  endfunction

  // Predict at acceptance and check each word in the same process.
  always @(posedge clk) begin
    cgbp_pkg::coef_t lanes[cgbp_pkg::IN_LANES];
    word_t w;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cgbp_pkg::REG_TRUNCATION_LEVEL) begin
          trunc_level = cfg_data;
        end else if (cfg_index == cgbp_pkg::REG_SIGNS_SEPARATE) begin
          signs_apart = cfg_data[0];
        end
      end
      if (start && !busy) begin
        lanes[0] = coef_lane0;
        lanes[1] = coef_lane1;
        lanes[2] = coef_lane2;
        lanes[3] = coef_lane3;
        pack_group(lanes, plane_count, valid_lanes);
      end
      if (result_valid) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: nibble %0h sign %0b plane %0d last %0b",
                 nibble, is_sign_nibble, plane_index, last);
          error_count++;
        end else begin
          w = expected_words.pop_front();
          if (nibble !== w.bits) begin
            $error("nibble: expected %0h, got %0h", w.bits, nibble);
            error_count++;
          end
          if (is_sign_nibble !== w.sign) begin
            $error("is_sign_nibble: expected %0b, got %0b", w.sign, is_sign_nibble);
            error_count++;
          end
          if (plane_index !== w.plane) begin
            $error("plane_index: expected %0d, got %0d", w.plane, plane_index);
            error_count++;
          end
          if (last !== w.last) begin
            $error("last: expected %0b, got %0b", w.last, last);
            error_count++;
          end
        end
      end
    end
  end

  // Hold the group until taken; start stays high for the caller to decide.
  task automatic send_group(cgbp_pkg::coef_t c0, cgbp_pkg::coef_t c1,
                            cgbp_pkg::coef_t c2, cgbp_pkg::coef_t c3,
                            cgbp_pkg::plane_t count,
                            logic [cgbp_pkg::VALID_W-1:0] valid);
    start       <= 1'b1;
    coef_lane0  <= c0;
    coef_lane1  <= c1;
    coef_lane2  <= c2;
    coef_lane3  <= c3;
    plane_count <= count;
    valid_lanes <= valid;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic sender_gap(int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop start, drain every expected word, then let a trailing empty group finish.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [cgbp_pkg::CFG_IDX_W-1:0] index,
                           logic [cgbp_pkg::CFG_DAT_W-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic cgbp_pkg::coef_t rand_coef();
    case ($urandom_range(9))
      0:       return 16'h8000;  // negative zero
      1:       return 16'hFFFF;
      2:       return 16'h0000;
      3:       return cgbp_pkg::coef_t'($urandom_range(255))
                      | {1'($urandom_range(1)), 15'h0};
      default: return cgbp_pkg::coef_t'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Reset settings: field extremes, lane masking and negative zero.
  task automatic test_directed_groups();
    send_group(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd0, 3'd4);
    send_group(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 3'd4);
    send_group(16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'd1, 3'd4);
    send_group(16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000, 4'd15, 3'd4);
    send_group(16'h0000, 16'h8000, 16'h0000, 16'hFFFF, 4'd15, 3'd4);
    send_group(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd3, 3'd0);
    for (int v = 1; v < 8; v++) begin
      send_group(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd2, 3'(v));
    end
    send_group(16'hA5A5, 16'h5A5A, 16'hC3C3, 16'h3C3C, 4'd15, 3'd4);
    send_group(16'h0001, 16'h8001, 16'h0000, 16'h8000, 4'd1, 3'd3);
    send_group(16'h4000, 16'h2000, 16'h1000, 16'h0800, 4'd14, 3'd4);
  endtask

  // Register extremes: everything truncated, single plane, no sign word.
  task automatic test_register_extremes();
    write_reg(cgbp_pkg::REG_TRUNCATION_LEVEL, 4'd15);
    send_group(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 3'd4);
    send_group(16'h8000, 16'h1234, 16'hFFFF, 16'h0000, 4'd0, 3'd4);
    write_reg(cgbp_pkg::REG_TRUNCATION_LEVEL, 4'd14);
    send_group(16'hC000, 16'h4000, 16'h8000, 16'hFFFF, 4'd15, 3'd4);
    send_group(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd14, 3'd4);
    write_reg(cgbp_pkg::REG_SIGNS_SEPARATE, 4'd1);
    send_group(16'hC000, 16'h4000, 16'h8000, 16'hFFFF, 4'd15, 3'd4);
    write_reg(cgbp_pkg::REG_TRUNCATION_LEVEL, 4'd0);
    send_group(16'h8001, 16'h0001, 16'h8000, 16'h0001, 4'd1, 3'd4);
    send_group(16'hFFFF, 16'h8000, 16'h7FFF, 16'h0F0F, 4'd15, 3'd4);
    write_reg(cgbp_pkg::REG_SIGNS_SEPARATE, 4'd0);
  endtask

  // Random groups under a random setting per batch.
  task automatic test_random_traffic(int idle_pct, int num_groups);
    int sent;
    int batch;
    int tl;
    int count;
    sent = 0;
    while (sent < num_groups) begin
      case ($urandom_range(9))
        0:       tl = 15;
        1:       tl = 0;
        default: tl = $urandom_range(7);
      endcase
      if ($urandom_range(3) == 0) begin
        write_reg(cgbp_pkg::CFG_IDX_W'($urandom_range(15, 2)),
                  cgbp_pkg::CFG_DAT_W'($urandom_range(15)));
      end
      if ($urandom_range(1)) begin
        write_reg(cgbp_pkg::REG_TRUNCATION_LEVEL, cgbp_pkg::CFG_DAT_W'(tl));
        write_reg(cgbp_pkg::REG_SIGNS_SEPARATE, cgbp_pkg::CFG_DAT_W'($urandom_range(15)));
      end else begin
        write_reg(cgbp_pkg::REG_SIGNS_SEPARATE, cgbp_pkg::CFG_DAT_W'($urandom_range(15)));
        write_reg(cgbp_pkg::REG_TRUNCATION_LEVEL, cgbp_pkg::CFG_DAT_W'(tl));
      end
      batch = (tl == 15) ? 5 : $urandom_range(35, 15);
      for (int i = 0; i < batch && sent < num_groups; i++) begin
        if (tl < 15 && $urandom_range(9) < 7) begin
          count = $urandom_range(15, tl + 1);
        end else begin
          count = $urandom_range(15);
        end
        sender_gap(idle_pct);
        send_group(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                   cgbp_pkg::plane_t'(count),
                   ($urandom_range(4) != 0) ? 3'($urandom_range(4, 1))
                                            : 3'($urandom_range(7)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_groups();
    test_register_extremes();
    test_random_traffic(22, 160);
    test_random_traffic(51, 160);
    test_random_traffic(0, 150);
    wait_idle();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
